// ----- src/g4c_pkg.sv -----
// shared types and codes for the gray4 colorize scanline decoder
`timescale 1ns / 1ps
`default_nettype none

package g4c_pkg;

    // pair command queue between the parse front and the pixel back end
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // one pixel pair to be produced by the back end
    typedef struct packed {
        logic       from_store;  // copy from the line store, else look up nibbles
        logic [3:0] hi_level;
        logic [3:0] lo_level;
        logic [9:0] x;           // source column of the left pixel
        logic [9:0] column;      // destination column with origin applied
        logic [9:0] row;         // destination row with origin applied
        logic       last;
    } pair_cmd_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_FORE_COLOR       = 3'd0,
        CFG_BACK_COLOR       = 3'd1,
        CFG_INVERT_COLORS    = 3'd2,
        CFG_COMPRESSED_MODE  = 3'd3,
        CFG_IMAGE_WIDTH      = 3'd4,
        CFG_SOURCE_ROW_BYTES = 3'd5,
        CFG_ORIGIN_X         = 3'd6,
        CFG_ORIGIN_Y         = 3'd7
    } cfg_index_t;

    // reasons for the front to hold off new transactions
    typedef struct packed {
        logic palette_busy;
        logic store_clearing;
    } hold_t;

endpackage

`default_nettype wire

// ----- src/g4c_palette.sv -----
// gray level to rgb565 palette, rebuilt by a short sweep after reset and color writes
`timescale 1ns / 1ps
`default_nettype none

module g4c_palette (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [23:0] fore_color,
    input  wire logic [23:0] back_color,
    input  wire logic        invert_colors,
    input  wire logic        rebuild,
    input  wire logic [3:0]  hi_level,
    input  wire logic [3:0]  lo_level,
    output logic      [15:0] hi_color,
    output logic      [15:0] lo_color,
    output logic             busy
);

    localparam logic [3:0]  LEVEL_MAX = 4'hF;
    localparam logic [11:0] RECIP15   = 12'd2185;  // 2^15 / 15, exact below 3840

    function automatic logic [11:0] blend_sum(input logic [7:0] f, input logic [7:0] b,
                                              input logic [3:0] lvl);
        logic [11:0] wb;
        logic [11:0] wf;
        begin
            wb = {8'd0, LEVEL_MAX - lvl} * {4'd0, b};
            wf = {8'd0, lvl} * {4'd0, f};
            return wb + wf;
        end
    endfunction

    function automatic logic [7:0] div15(input logic [11:0] v);
        logic [23:0] p;
        begin
            p = {12'd0, v} * {12'd0, RECIP15};
            return p[22:15];
        end
    endfunction

    logic        active_reg, active_next;
    logic [3:0]  level_reg, level_next;
    logic        stage_valid_reg, stage_valid_next;
    logic [3:0]  stage_level_reg;
    logic [11:0] sum_r_reg, sum_g_reg, sum_b_reg;
    logic [15:0] hi_pal_reg [16];
    logic [15:0] lo_pal_reg [16];

    logic [23:0] fc, bc;
    logic [7:0]  q_r, q_g, q_b;
    logic [15:0] packed_color;

    assign fc = invert_colors ? back_color : fore_color;
    assign bc = invert_colors ? fore_color : back_color;

    always_comb
    begin
        active_next      = active_reg;
        level_next       = level_reg;
        stage_valid_next = active_reg;
        if (rebuild)
        begin
            active_next = 1'b1;
            level_next  = 4'd0;
        end
        else if (active_reg)
        begin
            level_next = level_reg + 4'd1;
            if (level_reg == LEVEL_MAX)
                active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b1;
            level_reg       <= 4'd0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg      <= active_next;
            level_reg       <= level_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    // first stage: weighted channel sums
    always_ff @(posedge clk)
    begin
        stage_level_reg <= level_reg;
        sum_r_reg <= blend_sum(fc[23:16], bc[23:16], level_reg);
        sum_g_reg <= blend_sum(fc[15:8], bc[15:8], level_reg);
        sum_b_reg <= blend_sum(fc[7:0], bc[7:0], level_reg);
    end

    // second stage: divide by 15 and pack to 5-6-5
    assign q_r = div15(sum_r_reg);
    assign q_g = div15(sum_g_reg);
    assign q_b = div15(sum_b_reg);
    assign packed_color = {q_r[7:3], q_g[7:2], q_b[7:3]};

    always_ff @(posedge clk)
    begin
        if (stage_valid_reg)
        begin
            hi_pal_reg[stage_level_reg] <= packed_color;
            lo_pal_reg[stage_level_reg] <= packed_color;
        end
    end

    assign hi_color = hi_pal_reg[hi_level];
    assign lo_color = lo_pal_reg[lo_level];
    assign busy     = active_reg || stage_valid_reg;

endmodule

`default_nettype wire

// ----- src/g4c_front.sv -----
// parse front: takes source bytes, tracks position and marker state, issues pair commands
`timescale 1ns / 1ps
`default_nettype none

module g4c_front
    import g4c_pkg::*;
#(
    parameter int MAX_WIDTH = 512
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       start_image,
    input  wire logic       compressed_mode,
    input  wire logic [9:0] image_width,
    input  wire logic [8:0] source_row_bytes,
    input  wire logic [8:0] origin_x,
    input  wire logic [8:0] origin_y,
    input  wire hold_t      hold,
    output logic            push,
    output pair_cmd_t       push_cmd,
    input  wire logic       q_full
);

    localparam int         WLIM = (MAX_WIDTH > 1023) ? 1023 : MAX_WIDTH;
    localparam logic [9:0] WCAP = 10'(WLIM);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PLAIN = 4'b0010,
        ST_LIT   = 4'b0100,
        ST_COPY  = 4'b1000
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [9:0]   col_reg, col_next;
    logic [9:0]   row_reg, row_next;
    logic [8:0]   bir_reg, bir_next;
    logic [7:0]   marker_reg, marker_next;
    logic [3:0]   pos_reg, pos_next;
    logic         expect_reg, expect_next;
    logic [7:0]   byte_reg;

    logic [9:0]  w, two_rb, data_bytes, row_len, x_plain, bir_inc, col_ext, col_sum;
    logic [8:0]  rb_eff;
    logic [3:0]  pos_inc;
    logic        plain_emit, plain_wrap, comp_emit, row_end, adv_done;
    logic        cur_bit, next_bit, comp_last, need_push, step_go, accept;

    // effective geometry
    assign w          = (image_width > WCAP) ? WCAP : image_width;
    assign rb_eff     = (source_row_bytes == 9'd0) ? 9'd1 : source_row_bytes;
    assign two_rb     = {rb_eff, 1'b0};
    assign data_bytes = 10'(({1'b0, w} + 11'd1) >> 1);
    assign row_len    = ({1'b0, rb_eff} > data_bytes) ? {1'b0, rb_eff} : data_bytes;

    // plain mode step
    assign x_plain    = {bir_reg, 1'b0};
    assign bir_inc    = {1'b0, bir_reg} + 10'd1;
    assign plain_emit = x_plain < w;
    assign plain_wrap = bir_inc >= row_len;

    // compressed mode step
    assign col_ext   = col_reg;
    assign col_sum   = col_ext + 10'd2;
    assign comp_emit = col_ext < w;
    assign row_end   = col_sum >= two_rb;
    assign pos_inc   = pos_reg + 4'd1;
    assign adv_done  = row_end || pos_inc[3];
    assign cur_bit   = marker_reg[~pos_reg[2:0]];
    assign next_bit  = marker_reg[~pos_inc[2:0]];
    // no later pair of this byte is output once the run stops or leaves the image
    assign comp_last = adv_done || next_bit || (col_sum >= w);

    always_comb
    begin
        case (state_reg)
            ST_PLAIN: need_push = plain_emit;
            ST_LIT:   need_push = comp_emit;
            ST_COPY:  need_push = !cur_bit && comp_emit;
            default:  need_push = 1'b0;
        endcase
    end

    assign step_go  = !need_push || !q_full;
    assign push     = need_push && !q_full;
    assign in_ready = (state_reg == ST_IDLE) && !hold.palette_busy && !hold.store_clearing;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        push_cmd.from_store = (state_reg == ST_COPY);
        push_cmd.hi_level   = byte_reg[7:4];
        push_cmd.lo_level   = byte_reg[3:0];
        push_cmd.x          = (state_reg == ST_PLAIN) ? x_plain : col_ext;
        push_cmd.column     = {1'b0, origin_x} + push_cmd.x;
        push_cmd.row        = {1'b0, origin_y} + row_reg;
        push_cmd.last       = (state_reg == ST_PLAIN) ? 1'b1 : comp_last;
    end

    always_comb
    begin
        state_next  = state_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        bir_next    = bir_reg;
        marker_next = marker_reg;
        pos_next    = pos_reg;
        expect_next = expect_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (start_image)
                    begin
                        col_next    = 10'd0;
                        row_next    = 10'd0;
                        bir_next    = 9'd0;
                        marker_next = 8'd0;
                        pos_next    = 4'd0;
                        expect_next = 1'b0;
                    end
                    if (!compressed_mode)
                        state_next = ST_PLAIN;
                    else if (expect_reg && !start_image)
                        state_next = ST_LIT;
                    else
                    begin
                        marker_next = data_byte;
                        pos_next    = 4'd0;
                        state_next  = ST_COPY;
                    end
                end
            end
            ST_PLAIN:
            begin
                if (step_go)
                begin
                    if (plain_wrap)
                    begin
                        bir_next = 9'd0;
                        row_next = row_reg + 10'd1;
                    end
                    else
                        bir_next = bir_inc[8:0];
                    state_next = ST_IDLE;
                end
            end
            ST_LIT, ST_COPY:
            begin
                if ((state_reg == ST_COPY) && cur_bit)
                begin
                    // set bit: a literal byte comes next
                    expect_next = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (step_go)
                begin
                    if (row_end)
                    begin
                        col_next = 10'd0;
                        row_next = row_reg + 10'd1;
                        pos_next = 4'd8;
                    end
                    else
                    begin
                        col_next = col_sum;
                        pos_next = pos_inc;
                    end
                    if (adv_done)
                    begin
                        expect_next = 1'b0;
                        state_next  = ST_IDLE;
                    end
                    else
                        state_next = ST_COPY;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            col_reg    <= 10'd0;
            row_reg    <= 10'd0;
            bir_reg    <= 9'd0;
            marker_reg <= 8'd0;
            pos_reg    <= 4'd0;
            expect_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            bir_reg    <= bir_next;
            marker_reg <= marker_next;
            pos_reg    <= pos_next;
            expect_reg <= expect_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            byte_reg <= data_byte;
    end

endmodule

`default_nettype wire

// ----- src/g4c_queue.sv -----
// short fifo of pair commands between front and back
`timescale 1ns / 1ps
`default_nettype none

module g4c_queue
    import g4c_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire pair_cmd_t push_cmd,
    output logic           full,
    input  wire logic      pop,
    output pair_cmd_t      head,
    output logic           empty
);

    localparam logic [QAW-1:0] LAST_SLOT = QAW'(QDEPTH - 1);
    localparam logic [QAW:0]   FULL_CNT  = (QAW + 1)'(QDEPTH);

    pair_cmd_t      slot_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

// ----- src/g4c_back.sv -----
// pixel back end: line store, palette lookup, store update and output register
`timescale 1ns / 1ps
`default_nettype none

module g4c_back
    import g4c_pkg::*;
#(
    parameter int MAX_WIDTH = 512
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire pair_cmd_t   head,
    input  wire logic        q_empty,
    output logic             pop,
    output logic      [3:0]  hi_level,
    output logic      [3:0]  lo_level,
    input  wire logic [15:0] hi_color,
    input  wire logic [15:0] lo_color,
    output logic             store_clearing,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [15:0] pixel_left,
    output logic      [15:0] pixel_right,
    output logic      [9:0]  out_column,
    output logic      [9:0]  out_row,
    output logic             last_of_run
);

    localparam int WLIM  = (MAX_WIDTH > 1023) ? 1023 : MAX_WIDTH;
    localparam int DEPTH = (WLIM + 1) / 2;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    // one entry per pixel pair, left pixel in the upper half
    logic [31:0]   store_reg [DEPTH];
    logic [31:0]   rd_data_reg;
    logic          clearing_reg, clearing_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    logic          s1_valid_reg, s1_valid_next;
    pair_cmd_t     s1_cmd_reg;
    logic          fwd_hit_reg;
    logic [31:0]   fwd_data_reg;
    logic          out_valid_reg, out_valid_next;

    logic [AW-1:0] rd_addr, s1_addr, wr_addr;
    logic [31:0]   store_word, pair_word, wr_data;
    logic          xfer, wr_en;

    assign rd_addr = head.x[AW:1];
    assign s1_addr = s1_cmd_reg.x[AW:1];

    assign hi_level = s1_cmd_reg.hi_level;
    assign lo_level = s1_cmd_reg.lo_level;

    // read during the same edge as a write to that entry sees the old word
    assign store_word = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign pair_word  = s1_cmd_reg.from_store ? store_word : {hi_color, lo_color};

    assign xfer = s1_valid_reg && (!out_valid_reg || out_ready);
    assign pop  = !q_empty && !clearing_reg && (!s1_valid_reg || xfer);

    assign wr_en   = clearing_reg || xfer;
    assign wr_addr = clearing_reg ? clr_addr_reg : s1_addr;
    assign wr_data = clearing_reg ? 32'd0 : pair_word;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_reg[wr_addr] <= wr_data;
        if (pop)
            rd_data_reg <= store_reg[rd_addr];
    end

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR)
                clearing_next = 1'b0;
        end
        s1_valid_next = pop ? 1'b1 : (xfer ? 1'b0 : s1_valid_reg);
        out_valid_next = xfer ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clr_addr_reg  <= clr_addr_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_cmd_reg   <= head;
            fwd_hit_reg  <= xfer && (s1_addr == rd_addr);
            fwd_data_reg <= pair_word;
        end
        if (xfer)
        begin
            pixel_left  <= pair_word[31:16];
            pixel_right <= pair_word[15:0];
            out_column  <= s1_cmd_reg.column;
            out_row     <= s1_cmd_reg.row;
            last_of_run <= s1_cmd_reg.last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign store_clearing = clearing_reg;

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("pop from empty command queue");

    a_idle_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> (!s1_valid_reg && !out_valid_reg))
        else $error("pair in flight during line store clear");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |=> s1_valid_reg)
        else $error("pending pair lost while output stalled");

endmodule

`default_nettype wire

// ----- src/gray4_colorize_scanline_decoder_core.sv -----
// top level of the gray4 colorize scanline decoder
//
//  channel   direction  handshake             payload
//  in        sink       in_valid / in_ready   data_byte, start_image
//  out       source     out_valid / out_ready pixel_left, pixel_right, out_column,
//                                             out_row, last_of_run
//  cfg       sink       cfg_write_en          cfg_index, cfg_data
//
// the front sequencer steps one pixel pair per cycle unless the queue is full; a plain byte
// gives one pair, a marker byte walks its bits, a literal a pair then the bits after it
// results leave through a 4 deep command queue, a store read stage and the output register
// after reset the line store is zeroed one pair entry a cycle (half the capped width, 256 at
// the default) while the palette is built; in_ready stays low meanwhile
// a write of fore_color, back_color or invert_colors rebuilds the palette
// out_ready low backs up the output register, the queue and then the front
`timescale 1ns / 1ps
`default_nettype none

module gray4_colorize_scanline_decoder_core
    import g4c_pkg::*;
#(
    parameter int MAX_WIDTH = 512
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // source byte transactions
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        start_image,
    // pixel pair transactions
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [15:0] pixel_left,
    output logic      [15:0] pixel_right,
    output logic      [9:0]  out_column,
    output logic      [9:0]  out_row,
    output logic             last_of_run,
    // configuration writes
    input  wire logic        cfg_write_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    // configuration registers
    logic [23:0] fore_color_reg;
    logic [23:0] back_color_reg;
    logic        invert_colors_reg;
    logic        compressed_mode_reg;
    logic [9:0]  image_width_reg;
    logic [8:0]  source_row_bytes_reg;
    logic [8:0]  origin_x_reg;
    logic [8:0]  origin_y_reg;

    cfg_index_t  cfg_sel;
    logic        palette_rebuild;
    logic        palette_busy;
    logic        store_clearing;
    hold_t       hold;

    // front to queue
    logic        q_push;
    pair_cmd_t   q_push_cmd;
    logic        q_full;
    // queue to back
    logic        q_pop;
    pair_cmd_t   q_head;
    logic        q_empty;
    // back to palette lookup
    logic [3:0]  hi_level;
    logic [3:0]  lo_level;
    logic [15:0] hi_color;
    logic [15:0] lo_color;

    assign cfg_sel = cfg_index_t'(cfg_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fore_color_reg       <= 24'h000000;
            back_color_reg       <= 24'hFFFFFF;
            invert_colors_reg    <= 1'b0;
            compressed_mode_reg  <= 1'b0;
            image_width_reg      <= 10'd0;
            source_row_bytes_reg <= 9'd1;
            origin_x_reg         <= 9'd0;
            origin_y_reg         <= 9'd0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_sel)
                CFG_FORE_COLOR:       fore_color_reg       <= cfg_data;
                CFG_BACK_COLOR:       back_color_reg       <= cfg_data;
                CFG_INVERT_COLORS:    invert_colors_reg    <= cfg_data[0];
                CFG_COMPRESSED_MODE:  compressed_mode_reg  <= cfg_data[0];
                CFG_IMAGE_WIDTH:      image_width_reg      <= cfg_data[9:0];
                CFG_SOURCE_ROW_BYTES: source_row_bytes_reg <= cfg_data[8:0];
                CFG_ORIGIN_X:         origin_x_reg         <= cfg_data[8:0];
                CFG_ORIGIN_Y:         origin_y_reg         <= cfg_data[8:0];
                default:              ;
            endcase
        end
    end

    // any color change invalidates the palette
    assign palette_rebuild = cfg_write_en && ((cfg_sel == CFG_FORE_COLOR) ||
                                              (cfg_sel == CFG_BACK_COLOR) ||
                                              (cfg_sel == CFG_INVERT_COLORS));

    assign hold.palette_busy   = palette_busy;
    assign hold.store_clearing = store_clearing;

    g4c_palette u_palette (
        .clk           (clk),
        .rst_n         (rst_n),
        .fore_color    (fore_color_reg),
        .back_color    (back_color_reg),
        .invert_colors (invert_colors_reg),
        .rebuild       (palette_rebuild),
        .hi_level      (hi_level),
        .lo_level      (lo_level),
        .hi_color      (hi_color),
        .lo_color      (lo_color),
        .busy          (palette_busy)
    );

    // parse front: position, row and marker tracking
    g4c_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .start_image      (start_image),
        .compressed_mode  (compressed_mode_reg),
        .image_width      (image_width_reg),
        .source_row_bytes (source_row_bytes_reg),
        .origin_x         (origin_x_reg),
        .origin_y         (origin_y_reg),
        .hold             (hold),
        .push             (q_push),
        .push_cmd         (q_push_cmd),
        .q_full           (q_full)
    );

    g4c_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    // back end: line store and output register
    g4c_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (q_head),
        .q_empty        (q_empty),
        .pop            (q_pop),
        .hi_level       (hi_level),
        .lo_level       (lo_level),
        .hi_color       (hi_color),
        .lo_color       (lo_color),
        .store_clearing (store_clearing),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pixel_left     (pixel_left),
        .pixel_right    (pixel_right),
        .out_column     (out_column),
        .out_row        (out_row),
        .last_of_run    (last_of_run)
    );

    a_accept_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> (!palette_busy && !store_clearing))
        else $error("transaction accepted while palette or line store not ready");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("pair command pushed into full queue");

endmodule

`default_nettype wire
